/* src/gf2mv_pkg.sv */
`default_nettype none

package gf2mv_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // fixed field widths
    localparam int ACT_W  = 3;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;
    localparam int WGT_W  = 7;
    localparam int DIM_W  = 7;
    localparam int Y_W    = 64;
    localparam int CFG_AW = 1;

    // actions
    localparam logic [ACT_W-1:0] ACT_SET    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ZERO   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_VECTOR = 3'd4;

    // result status
    localparam logic [STAT_W-1:0] STS_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STS_NO_CHANGE = 2'd1;
    localparam logic [STAT_W-1:0] STS_RANGE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_COLS_IN_USE = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } dp_stat_t;

endpackage

`default_nettype wire

/* src/gf2_sparse_matrix_vector_engine.sv */
// GF(2) matrix store with a bit-serial matrix-vector multiply.
// Input channel (s_*): one beat per action - set, clear or get one entry,
//   zero the whole matrix, or feed one input-vector bit x[col].
// Result channel (m_*): exactly one beat per input beat, in order, carrying
//   status, the get bit, the running output vector and the weight maxima.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata, single-cycle writes. The user
//   must write them only while the block is idle; the block does not
//   enforce it. Index 0 = rows in use, 1 = columns in use.
// Sequence: an item is accepted, then executed against the row and column
//   RAMs (one registered read each). A clear that removes the current
//   maximum row or column weight adds a sweep through both RAMs. The result
//   is then loaded into the output register once it is free.
// The matrix is held twice, as rows and as columns, so a vector bit reads
//   a whole column in one access.
// Stall: a finished result waits until the output register is free; the
//   next item is still accepted as long as that result can move out.
// Reset: synchronous, active low. Clears every entry (per-entry valid bits),
//   weights, maxima and the accumulator at once; registers go to 64.
`default_nettype none

module gf2_sparse_matrix_vector_engine #(
    parameter int MAX_ROWS = gf2mv_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gf2mv_pkg::MAX_COLS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [gf2mv_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [gf2mv_pkg::DIM_W-1:0]     cfg_wdata,
    // input beats
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [gf2mv_pkg::ACT_W-1:0]     s_action,
    input  wire logic [gf2mv_pkg::IDX_W-1:0]     s_row_index,
    input  wire logic [gf2mv_pkg::IDX_W-1:0]     s_col_index,
    input  wire logic                            s_x_bit,
    input  wire logic                            s_start_vector,
    // result beats
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [gf2mv_pkg::STAT_W-1:0]    m_status,
    output logic                                 m_entry_bit,
    output logic      [gf2mv_pkg::Y_W-1:0]       m_y_vector,
    output logic      [gf2mv_pkg::WGT_W-1:0]     m_max_row_weight,
    output logic      [gf2mv_pkg::WGT_W-1:0]     m_max_col_weight
);

    gf2mv_pkg::ctl_cmd_t cmd;
    gf2mv_pkg::dp_stat_t stat;

    // sequencing: accept, execute, optional maximum sweep, emit
    gf2mv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // matrix RAMs, weights, accumulator and the output register
    gf2mv_dpath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_action         (s_action),
        .s_row_index      (s_row_index),
        .s_col_index      (s_col_index),
        .s_x_bit          (s_x_bit),
        .s_start_vector   (s_start_vector),
        .cmd              (cmd),
        .stat             (stat),
        .m_status         (m_status),
        .m_entry_bit      (m_entry_bit),
        .m_y_vector       (m_y_vector),
        .m_max_row_weight (m_max_row_weight),
        .m_max_col_weight (m_max_col_weight)
    );

endmodule

`default_nettype wire

/* src/gf2mv_ram.sv */
`default_nettype none

module gf2mv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/gf2mv_ctrl.sv */
`default_nettype none

module gf2mv_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire gf2mv_pkg::dp_stat_t stat,
    output gf2mv_pkg::ctl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   pending_reg, pending_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;
    logic   emit;

    // output slot can take a beat this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && (!pending_reg || out_free);
    assign accept   = s_valid && s_ready;
    assign emit     = (state_reg == ST_IDLE) && pending_reg && out_free;

    assign cmd.capture = accept;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.scan    = (state_reg == ST_SCAN);
    assign cmd.emit    = emit;

    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            pending_next = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                pending_next = 1'b1;
                state_next   = stat.need_scan ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // an accepted item always goes straight to execution
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter execution");

    // a finished item leaves a pending result
    a_exec_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> pending_reg)
        else $error("executed item left no pending result");

    // a result never overwrites a beat that is still stalled
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a stalled beat");

    // no new item while an older result has nowhere to go
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && pending_reg) |-> emit)
        else $error("item accepted while a result is stuck");

endmodule

`default_nettype wire

/* src/gf2mv_dpath.sv */
`default_nettype none

module gf2mv_dpath #(
    parameter int MAX_ROWS = gf2mv_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gf2mv_pkg::MAX_COLS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [gf2mv_pkg::CFG_AW-1:0]       cfg_addr,
    input  wire logic [gf2mv_pkg::DIM_W-1:0]        cfg_wdata,
    input  wire logic [gf2mv_pkg::ACT_W-1:0]        s_action,
    input  wire logic [gf2mv_pkg::IDX_W-1:0]        s_row_index,
    input  wire logic [gf2mv_pkg::IDX_W-1:0]        s_col_index,
    input  wire logic                               s_x_bit,
    input  wire logic                               s_start_vector,
    input  wire gf2mv_pkg::ctl_cmd_t                cmd,
    output gf2mv_pkg::dp_stat_t                     stat,
    output logic      [gf2mv_pkg::STAT_W-1:0]       m_status,
    output logic                                    m_entry_bit,
    output logic      [gf2mv_pkg::Y_W-1:0]          m_y_vector,
    output logic      [gf2mv_pkg::WGT_W-1:0]        m_max_row_weight,
    output logic      [gf2mv_pkg::WGT_W-1:0]        m_max_col_weight
);

    localparam int RAW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CAW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int WW       = gf2mv_pkg::WGT_W;
    localparam int DW       = gf2mv_pkg::DIM_W;
    localparam int ROW_MW   = MAX_COLS + WW;
    localparam int COL_MW   = MAX_ROWS + WW;
    localparam int SCAN_LEN = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CNT_W    = $clog2(SCAN_LEN + 1);
    localparam logic [MAX_COLS-1:0] ONE_C = 1;
    localparam logic [MAX_ROWS-1:0] ONE_R = 1;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                                input logic [DW-1:0] hi);
        logic [DW-1:0] r;
        r = v;
        if (v == '0) begin
            r = DW'(1);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // configuration
    logic [DW-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [DW-1:0] nr, nc;

    // captured item
    logic [gf2mv_pkg::ACT_W-1:0] action_reg;
    logic [gf2mv_pkg::IDX_W-1:0] row_idx_reg, col_idx_reg;
    logic                        x_bit_reg, start_reg;

    // memories and their entry-valid bits
    logic [MAX_ROWS-1:0] row_vld_reg;
    logic [MAX_COLS-1:0] col_vld_reg;
    logic                rrd_vld_reg, crd_vld_reg;
    logic [RAW-1:0]      row_raddr, r_a;
    logic [CAW-1:0]      col_raddr, c_a;
    logic [ROW_MW-1:0]   row_rdata, row_word, row_wdata;
    logic [COL_MW-1:0]   col_rdata, col_word, col_wdata;
    logic                row_we, col_we, vld_clear;
    logic [MAX_COLS-1:0] row_bits;
    logic [MAX_ROWS-1:0] col_bits;
    logic [WW-1:0]       row_w, col_w;

    // running state
    logic [MAX_ROWS-1:0] acc_reg, acc_next;
    logic [WW-1:0]       max_r_reg, max_r_next, max_c_reg, max_c_next;
    logic [gf2mv_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic                res_entry_reg, res_entry_next;
    logic                scan_rows_reg, scan_rows_next, scan_cols_reg, scan_cols_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                take_r_reg, take_c_reg;
    logic                row_ok, col_ok, cur_bit;
    logic [MAX_ROWS-1:0] row_mask;

    // output beat
    logic [gf2mv_pkg::STAT_W-1:0] m_status_reg;
    logic                         m_entry_bit_reg;
    logic [gf2mv_pkg::Y_W-1:0]    m_y_vector_reg;
    logic [WW-1:0]                m_max_row_weight_reg, m_max_col_weight_reg;

    assign nr = clamp_dim(rows_cfg_reg, DW'(MAX_ROWS));
    assign nc = clamp_dim(cols_cfg_reg, DW'(MAX_COLS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= gf2mv_pkg::DIM_RESET;
            cols_cfg_reg <= gf2mv_pkg::DIM_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gf2mv_pkg::CFG_ROWS_IN_USE: rows_cfg_reg <= cfg_wdata;
                gf2mv_pkg::CFG_COLS_IN_USE: cols_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg  <= s_action;
            row_idx_reg <= s_row_index;
            col_idx_reg <= s_col_index;
            x_bit_reg   <= s_x_bit;
            start_reg   <= s_start_vector;
        end
    end

    // reads come from the item ports on capture, from the sweep counter on scan
    assign row_raddr = cmd.scan ? cnt_reg[RAW-1:0] : s_row_index[RAW-1:0];
    assign col_raddr = cmd.scan ? cnt_reg[CAW-1:0] : s_col_index[CAW-1:0];
    assign r_a       = row_idx_reg[RAW-1:0];
    assign c_a       = col_idx_reg[CAW-1:0];

    gf2mv_ram #(.WIDTH(ROW_MW), .DEPTH(MAX_ROWS)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (r_a),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    gf2mv_ram #(.WIDTH(COL_MW), .DEPTH(MAX_COLS)) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (c_a),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    always_ff @(posedge aclk) begin
        rrd_vld_reg <= row_vld_reg[row_raddr];
        crd_vld_reg <= col_vld_reg[col_raddr];
    end

    // unwritten entries read as zero
    assign row_word = rrd_vld_reg ? row_rdata : '0;
    assign col_word = crd_vld_reg ? col_rdata : '0;
    assign row_bits = row_word[MAX_COLS-1:0];
    assign row_w    = row_word[ROW_MW-1:MAX_COLS];
    assign col_bits = col_word[MAX_ROWS-1:0];
    assign col_w    = col_word[COL_MW-1:MAX_ROWS];

    always_comb begin
        for (int i = 0; i < MAX_ROWS; i++) begin
            row_mask[i] = (DW'(i) < nr);
        end
    end

    assign row_ok  = (DW'(row_idx_reg) < nr);
    assign col_ok  = (DW'(col_idx_reg) < nc);
    assign cur_bit = row_bits[c_a];

    always_comb begin
        row_we          = 1'b0;
        col_we          = 1'b0;
        vld_clear       = 1'b0;
        row_wdata       = row_word;
        col_wdata       = col_word;
        acc_next        = acc_reg;
        max_r_next      = max_r_reg;
        max_c_next      = max_c_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        scan_rows_next  = scan_rows_reg;
        scan_cols_next  = scan_cols_reg;
        cnt_next        = cnt_reg;

        if (cmd.exec) begin
            res_status_next = gf2mv_pkg::STS_DONE;
            res_entry_next  = 1'b0;
            scan_rows_next  = 1'b0;
            scan_cols_next  = 1'b0;
            cnt_next        = '0;
            case (action_reg)
                gf2mv_pkg::ACT_SET: begin
                    if (!(row_ok && col_ok)) begin
                        res_status_next = gf2mv_pkg::STS_RANGE;
                    end else if (cur_bit) begin
                        res_status_next = gf2mv_pkg::STS_NO_CHANGE;
                    end else begin
                        row_we    = 1'b1;
                        col_we    = 1'b1;
                        row_wdata = {WW'(row_w + WW'(1)), row_bits | (ONE_C << c_a)};
                        col_wdata = {WW'(col_w + WW'(1)), col_bits | (ONE_R << r_a)};
                        if (WW'(row_w + WW'(1)) > max_r_reg) begin
                            max_r_next = WW'(row_w + WW'(1));
                        end
                        if (WW'(col_w + WW'(1)) > max_c_reg) begin
                            max_c_next = WW'(col_w + WW'(1));
                        end
                    end
                end
                gf2mv_pkg::ACT_CLEAR: begin
                    if (!(row_ok && col_ok)) begin
                        res_status_next = gf2mv_pkg::STS_RANGE;
                    end else if (!cur_bit) begin
                        res_status_next = gf2mv_pkg::STS_NO_CHANGE;
                    end else begin
                        row_we    = 1'b1;
                        col_we    = 1'b1;
                        row_wdata = {WW'(row_w - WW'(1)), row_bits & ~(ONE_C << c_a)};
                        col_wdata = {WW'(col_w - WW'(1)), col_bits & ~(ONE_R << r_a)};
                        // the old weight was the maximum: sweep for the new one
                        if (max_r_reg == row_w) begin
                            scan_rows_next = 1'b1;
                            max_r_next     = '0;
                        end
                        if (max_c_reg == col_w) begin
                            scan_cols_next = 1'b1;
                            max_c_next     = '0;
                        end
                    end
                end
                gf2mv_pkg::ACT_GET: begin
                    if (!(row_ok && col_ok)) begin
                        res_status_next = gf2mv_pkg::STS_RANGE;
                    end else begin
                        res_entry_next = cur_bit;
                    end
                end
                gf2mv_pkg::ACT_ZERO: begin
                    vld_clear  = 1'b1;
                    max_r_next = '0;
                    max_c_next = '0;
                end
                gf2mv_pkg::ACT_VECTOR: begin
                    if (!col_ok) begin
                        res_status_next = gf2mv_pkg::STS_RANGE;
                    end else begin
                        acc_next = (start_reg ? '0 : acc_reg)
                                 ^ (x_bit_reg ? (col_bits & row_mask) : '0);
                    end
                end
                default: begin
                    res_status_next = gf2mv_pkg::STS_NO_CHANGE;
                end
            endcase
        end else begin
            if (cmd.scan && (cnt_reg != CNT_W'(SCAN_LEN))) begin
                cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
            end
            // read data arrives in the cycle after the sweep address
            if (take_r_reg && scan_rows_reg && (row_w > max_r_reg)) begin
                max_r_next = row_w;
            end
            if (take_c_reg && scan_cols_reg && (col_w > max_c_reg)) begin
                max_c_next = col_w;
            end
        end
    end

    assign stat.need_scan = cmd.exec && (scan_rows_next || scan_cols_next);
    assign stat.scan_done = (cnt_reg == CNT_W'(SCAN_LEN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg   <= '0;
            col_vld_reg   <= '0;
            acc_reg       <= '0;
            max_r_reg     <= '0;
            max_c_reg     <= '0;
            scan_rows_reg <= 1'b0;
            scan_cols_reg <= 1'b0;
            cnt_reg       <= '0;
            take_r_reg    <= 1'b0;
            take_c_reg    <= 1'b0;
        end else begin
            if (vld_clear) begin
                row_vld_reg <= '0;
                col_vld_reg <= '0;
            end else begin
                if (row_we) begin
                    row_vld_reg[r_a] <= 1'b1;
                end
                if (col_we) begin
                    col_vld_reg[c_a] <= 1'b1;
                end
            end
            acc_reg       <= acc_next;
            max_r_reg     <= max_r_next;
            max_c_reg     <= max_c_next;
            scan_rows_reg <= scan_rows_next;
            scan_cols_reg <= scan_cols_next;
            cnt_reg       <= cnt_next;
            take_r_reg    <= cmd.scan && (8'(cnt_reg) < 8'(nr));
            take_c_reg    <= cmd.scan && (8'(cnt_reg) < 8'(nc));
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        if (cmd.emit) begin
            m_status_reg         <= res_status_reg;
            m_entry_bit_reg      <= res_entry_reg;
            m_y_vector_reg       <= gf2mv_pkg::Y_W'(acc_reg);
            m_max_row_weight_reg <= max_r_reg;
            m_max_col_weight_reg <= max_c_reg;
        end
    end

    assign m_status         = m_status_reg;
    assign m_entry_bit      = m_entry_bit_reg;
    assign m_y_vector       = m_y_vector_reg;
    assign m_max_row_weight = m_max_row_weight_reg;
    assign m_max_col_weight = m_max_col_weight_reg;

endmodule

`default_nettype wire

/* sim/gf2_sparse_matrix_vector_engine_test.sv */
`default_nettype none

module gf2_sparse_matrix_vector_engine_test;

    import gf2mv_pkg::*;

    // Action codes the block must treat as no-ops (status "no change").
    localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

    // Random part: ten register settings, ~165 beats under each.
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 165;
    localparam int DIR_N       = 30;

    // Slowest beat: execute + max rescan + output slot, with the receiver's
    // sparsest stall pattern on top and the one long hold-off of HOLD_CYCLES.
    // STALL_LIMIT idle cycles is well beyond any correct run.
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             x_bit;
        logic             start;
    } mv_beat_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              entry_bit;
        logic [Y_W-1:0]    y_vec;
        logic [WGT_W-1:0]  max_row;
        logic [WGT_W-1:0]  max_col;
    } mv_result_t;

    // Directed table rows: a plain beat (predicted), a beat with its result typed
    // in, or a register write (done only once the block has drained).
    typedef enum logic [1:0] {ROW_BEAT, ROW_CHECKED, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CFG_AW-1:0] reg_idx;
        logic [DIM_W-1:0]  reg_val;
        mv_beat_t          beat;
        mv_result_t        want;
    } dir_row_t;

    // ---------------------------------------------------------------------
    // DUT signals; every input known from time 0
    // ---------------------------------------------------------------------
    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              cfg_wr_en      = 1'b0;
    logic [CFG_AW-1:0] cfg_addr       = CFG_ROWS_IN_USE;
    logic [DIM_W-1:0]  cfg_wdata      = '0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [ACT_W-1:0]  s_action       = ACT_GET;
    logic [IDX_W-1:0]  s_row_index    = '0;
    logic [IDX_W-1:0]  s_col_index    = '0;
    logic              s_x_bit        = 1'b0;
    logic              s_start_vector = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic              m_entry_bit;
    logic [Y_W-1:0]    m_y_vector;
    logic [WGT_W-1:0]  m_max_row_weight;
    logic [WGT_W-1:0]  m_max_col_weight;

    gf2_sparse_matrix_vector_engine i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_row_index      (s_row_index),
        .s_col_index      (s_col_index),
        .s_x_bit          (s_x_bit),
        .s_start_vector   (s_start_vector),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_bit      (m_entry_bit),
        .m_y_vector       (m_y_vector),
        .m_max_row_weight (m_max_row_weight),
        .m_max_col_weight (m_max_col_weight)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Matrix shadow: the state the block should hold after every beat
    // ---------------------------------------------------------------------
    logic [MAX_COLS_DEF-1:0] held_rows [MAX_ROWS_DEF];   // bit c of row r = entry (r,c)
    logic [WGT_W-1:0]        row_ones  [MAX_ROWS_DEF];
    logic [WGT_W-1:0]        col_ones  [MAX_COLS_DEF];
    logic [WGT_W-1:0]        peak_row_ones;
    logic [WGT_W-1:0]        peak_col_ones;
    logic [Y_W-1:0]          y_acc;
    logic [DIM_W-1:0]        rows_reg;
    logic [DIM_W-1:0]        cols_reg;

    mv_result_t due_results [$];   // results owed by the block, oldest first
    int         fail_count  = 0;
    int         beats_sent  = 0;
    int         burst_left  = 0;
    bit         hold_req    = 1'b0;

    // Register value as the block uses it: 0 acts as 1, above the max clamps.
    function automatic int dim_used(input logic [DIM_W-1:0] v, input int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : int'(v);
    endfunction

    function automatic logic [WGT_W-1:0] peak_of(input logic [WGT_W-1:0] wts [MAX_ROWS_DEF],
                                                 input int n);
        logic [WGT_W-1:0] pk;
        pk = '0;
        for (int i = 0; i < n; i++)
            if (wts[i] > pk) pk = wts[i];
        return pk;
    endfunction

    // Apply one beat to the shadow matrix and return the result it must produce.
    task automatic apply_to_matrix(input mv_beat_t b, output mv_result_t res);
        int nr;
        int nc;
        int r;
        int c;
        bit hit;
        nr  = dim_used(rows_reg, MAX_ROWS_DEF);
        nc  = dim_used(cols_reg, MAX_COLS_DEF);
        r   = b.row;
        c   = b.col;
        hit = (r < nr) && (c < nc);
        res = '0;
        res.status = STS_DONE;
        case (b.action)
            ACT_SET: begin
                if (!hit) begin
                    res.status = STS_RANGE;
                end else if (held_rows[r][c]) begin
                    res.status = STS_NO_CHANGE;
                end else begin
                    held_rows[r][c] = 1'b1;
                    row_ones[r]++;
                    col_ones[c]++;
                    if (row_ones[r] > peak_row_ones) peak_row_ones = row_ones[r];
                    if (col_ones[c] > peak_col_ones) peak_col_ones = col_ones[c];
                end
            end
            ACT_CLEAR: begin
                if (!hit) begin
                    res.status = STS_RANGE;
                end else if (!held_rows[r][c]) begin
                    res.status = STS_NO_CHANGE;
                end else begin
                    held_rows[r][c] = 1'b0;
                    row_ones[r]--;
                    col_ones[c]--;
                    // removing the current peak forces a sweep over the sizes in use
                    if (peak_row_ones == row_ones[r] + 1) peak_row_ones = peak_of(row_ones, nr);
                    if (peak_col_ones == col_ones[c] + 1) peak_col_ones = peak_of(col_ones, nc);
                end
            end
            ACT_GET: begin
                if (!hit) res.status = STS_RANGE;
                else      res.entry_bit = held_rows[r][c];
            end
            ACT_ZERO: begin
                for (int i = 0; i < MAX_ROWS_DEF; i++) begin
                    held_rows[i] = '0;
                    row_ones[i]  = '0;
                end
                for (int j = 0; j < MAX_COLS_DEF; j++) col_ones[j] = '0;
                peak_row_ones = '0;
                peak_col_ones = '0;
            end
            ACT_VECTOR: begin
                // only the column is range-checked; a bad column leaves start alone too
                if (c >= nc) begin
                    res.status = STS_RANGE;
                end else begin
                    if (b.start) y_acc = '0;
                    if (b.x_bit)
                        for (int i = 0; i < nr; i++) y_acc[i] = y_acc[i] ^ held_rows[i][c];
                end
            end
            default: res.status = STS_NO_CHANGE;
        endcase
        res.y_vec   = y_acc;
        res.max_row = peak_row_ones;
        res.max_col = peak_col_ones;
    endtask

    // ---------------------------------------------------------------------
    // Sender: offers one beat, waits for the handshake, queues its result.
    // Beats go out in bursts of random length with random gaps between them.
    // ---------------------------------------------------------------------
    task automatic push_beat(input mv_beat_t b, input bit typed, input mv_result_t typed_res);
        mv_result_t pred;
        int         gap;
        s_valid        <= 1'b1;
        s_action       <= b.action;
        s_row_index    <= b.row;
        s_col_index    <= b.col;
        s_x_bit        <= b.x_bit;
        s_start_vector <= b.start;
        do @(posedge aclk); while (!s_ready);
        apply_to_matrix(b, pred);
        due_results.push_back(typed ? typed_res : pred);
        beats_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            // mostly short bursts, now and then a long gap-free stretch
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every owed result has come out.
    task automatic settle();
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_ROWS_IN_USE) rows_reg = val;
        else                        cols_reg = val;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic mv_beat_t random_beat();
        mv_beat_t b;
        int       p;
        p = $urandom_range(0, 99);
        if      (p < 30) b.action = ACT_SET;
        else if (p < 55) b.action = ACT_CLEAR;
        else if (p < 67) b.action = ACT_GET;
        else if (p < 92) b.action = ACT_VECTOR;
        else if (p < 94) b.action = ACT_ZERO;
        else             b.action = ACT_RSVD5 + ACT_W'($urandom_range(0, 2));
        // indices mostly inside the sizes in use, sometimes anywhere
        if ($urandom_range(0, 6) == 0)
            b.row = IDX_W'($urandom_range(0, 63));
        else
            b.row = IDX_W'($urandom_range(0, dim_used(rows_reg, MAX_ROWS_DEF) - 1));
        if ($urandom_range(0, 6) == 0)
            b.col = IDX_W'($urandom_range(0, 63));
        else
            b.col = IDX_W'($urandom_range(0, dim_used(cols_reg, MAX_COLS_DEF) - 1));
        b.x_bit = 1'($urandom);
        b.start = ($urandom_range(0, 3) == 0);
        return b;
    endfunction

    function automatic dir_row_t beat_row(input logic [ACT_W-1:0] act, input int r, input int c,
                                          input bit xb, input bit sv);
        dir_row_t d;
        d             = '0;
        d.kind        = ROW_BEAT;
        d.beat.action = act;
        d.beat.row    = IDX_W'(r);
        d.beat.col    = IDX_W'(c);
        d.beat.x_bit  = xb;
        d.beat.start  = sv;
        return d;
    endfunction

    function automatic dir_row_t checked_row(input logic [ACT_W-1:0] act, input int r,
                                             input int c, input bit xb, input bit sv,
                                             input logic [STAT_W-1:0] st, input bit eb,
                                             input logic [Y_W-1:0] y, input int mr,
                                             input int mc);
        dir_row_t d;
        d                = beat_row(act, r, c, xb, sv);
        d.kind           = ROW_CHECKED;
        d.want.status    = st;
        d.want.entry_bit = eb;
        d.want.y_vec     = y;
        d.want.max_row   = WGT_W'(mr);
        d.want.max_col   = WGT_W'(mc);
        return d;
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_AW-1:0] idx, input int val);
        dir_row_t d;
        d         = '0;
        d.kind    = ROW_REG;
        d.reg_idx = idx;
        d.reg_val = DIM_W'(val);
        return d;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    dir_row_t dir_tab [DIR_N];

    initial begin : stimulus
        mv_beat_t b;
        int       pick;
        int       len;
        int       nr;
        int       nc;
        int       r0;
        int       c0;
        int       rv;
        int       cv;
        int       phase_base;

        for (int i = 0; i < MAX_ROWS_DEF; i++) begin
            held_rows[i] = '0;
            row_ones[i]  = '0;
        end
        for (int j = 0; j < MAX_COLS_DEF; j++) col_ones[j] = '0;
        peak_row_ones = '0;
        peak_col_ones = '0;
        y_acc         = '0;
        rows_reg      = DIM_RESET;
        cols_reg      = DIM_RESET;

        // Directed part, starting from the reset state (64 x 64, all zero).
        dir_tab = '{
            checked_row(ACT_GET,    0,  0, 0, 0, STS_DONE,      0, '0, 0, 0),
            checked_row(ACT_SET,   63, 63, 0, 0, STS_DONE,      0, '0, 1, 1),
            checked_row(ACT_SET,   63, 63, 0, 0, STS_NO_CHANGE, 0, '0, 1, 1),
            checked_row(ACT_GET,   63, 63, 0, 0, STS_DONE,      1, '0, 1, 1),
            checked_row(ACT_SET,    0, 63, 0, 0, STS_DONE,      0, '0, 1, 2),
            checked_row(ACT_SET,    0,  0, 0, 0, STS_DONE,      0, '0, 2, 2),
            // column 63 holds rows 0 and 63
            checked_row(ACT_VECTOR, 0, 63, 1, 1, STS_DONE, 0, 64'h8000_0000_0000_0001, 2, 2),
            checked_row(ACT_VECTOR, 0,  0, 1, 0, STS_DONE, 0, 64'h8000_0000_0000_0000, 2, 2),
            // x bit zero with start: accumulator just clears
            checked_row(ACT_VECTOR, 0,  5, 0, 1, STS_DONE,      0, '0, 2, 2),
            // drops the column peak, forces a column rescan
            checked_row(ACT_CLEAR, 63, 63, 0, 0, STS_DONE,      0, '0, 2, 1),
            checked_row(ACT_CLEAR, 63, 63, 0, 0, STS_NO_CHANGE, 0, '0, 2, 1),
            // drops both peaks at once
            checked_row(ACT_CLEAR,  0,  0, 0, 0, STS_DONE,      0, '0, 1, 1),
            checked_row(ACT_RSVD5,  0,  0, 0, 0, STS_NO_CHANGE, 0, '0, 1, 1),
            checked_row(ACT_RSVD7, 63, 63, 1, 1, STS_NO_CHANGE, 0, '0, 1, 1),
            beat_row(ACT_RSVD6,    21, 42, 1, 0),
            checked_row(ACT_ZERO,  63, 63, 1, 1, STS_DONE,      0, '0, 0, 0),
            beat_row(ACT_SET,       5,  9, 1, 1),
            beat_row(ACT_VECTOR,    0,  9, 1, 1),
            // shrink to 3 x 5: out-of-range beats must leave everything alone
            reg_row(CFG_ROWS_IN_USE, 3),
            reg_row(CFG_COLS_IN_USE, 5),
            checked_row(ACT_SET,    3,  0, 0, 0, STS_RANGE, 0, 64'h20, 1, 1),
            checked_row(ACT_GET,    0,  5, 0, 0, STS_RANGE, 0, 64'h20, 1, 1),
            checked_row(ACT_VECTOR, 0,  5, 1, 1, STS_RANGE, 0, 64'h20, 1, 1),
            beat_row(ACT_VECTOR,   63,  4, 1, 1),
            beat_row(ACT_CLEAR,     2,  4, 0, 0),
            // register extremes: 0 acts as one row, 127 as 64 columns
            reg_row(CFG_ROWS_IN_USE, 0),
            reg_row(CFG_COLS_IN_USE, 127),
            checked_row(ACT_SET,    1, 63, 0, 0, STS_RANGE, 0, '0, 1, 1),
            beat_row(ACT_SET,       0, 63, 0, 0),
            beat_row(ACT_VECTOR,    0, 63, 1, 1)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < DIR_N; k++) begin
            if (dir_tab[k].kind == ROW_REG) begin
                settle();
                write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
            end else begin
                push_beat(dir_tab[k].beat, dir_tab[k].kind == ROW_CHECKED, dir_tab[k].want);
            end
        end

        // Random part: one register setting per phase, block drained in between.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0:       begin rv = DIM_RESET; cv = DIM_RESET; end
                1:       begin rv = 1;         cv = 1;         end
                2:       begin rv = 0;         cv = 0;         end
                3:       begin rv = 127;       cv = 127;       end
                4:       begin rv = DIM_RESET; cv = 1;         end
                5:       begin rv = 1;         cv = DIM_RESET; end
                6, 7:    begin rv = $urandom_range(1, 64);  cv = $urandom_range(1, 64);  end
                default: begin rv = $urandom_range(0, 127); cv = $urandom_range(0, 127); end
            endcase
            write_reg(CFG_ROWS_IN_USE, DIM_W'(rv));
            write_reg(CFG_COLS_IN_USE, DIM_W'(cv));
            // first phase: receiver holds off for a long stretch while beats keep coming
            if (ph == 0) hold_req = 1'b1;
            nr = dim_used(rows_reg, MAX_ROWS_DEF);
            nc = dim_used(cols_reg, MAX_COLS_DEF);
            phase_base = beats_sent;
            while (beats_sent - phase_base < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    push_beat(random_beat(), 1'b0, '0);
                end else if (pick < 75) begin
                    // one multiply pass over up to all columns in use: start on the first bit, then walk columns
                    len = $urandom_range(1, nc);
                    c0  = $urandom_range(0, nc - 1);
                    for (int j = 0; j < len; j++) begin
                        b = '{ACT_VECTOR, IDX_W'($urandom_range(0, 63)), IDX_W'((c0 + j) % nc),
                              1'($urandom), (j == 0)};
                        push_beat(b, 1'b0, '0);
                    end
                end else if (pick < 85) begin
                    // fill most of one row; a full row drives the row peak to its top
                    r0 = $urandom_range(0, nr - 1);
                    for (int j = 0; j < nc; j++) begin
                        if ($urandom_range(0, 7) != 0) begin
                            b = '{ACT_SET, IDX_W'(r0), IDX_W'(j), 1'($urandom), 1'($urandom)};
                            push_beat(b, 1'b0, '0);
                        end
                    end
                end else if (pick < 93) begin
                    c0 = $urandom_range(0, nc - 1);
                    for (int i = 0; i < nr; i++) begin
                        if ($urandom_range(0, 7) != 0) begin
                            b = '{ACT_SET, IDX_W'(i), IDX_W'(c0), 1'($urandom), 1'($urandom)};
                            push_beat(b, 1'b0, '0);
                        end
                    end
                end else begin
                    // wipe a row: repeated peak drops and rescans
                    r0 = $urandom_range(0, nr - 1);
                    for (int j = 0; j < nc; j++) begin
                        b = '{ACT_CLEAR, IDX_W'(r0), IDX_W'(j), 1'($urandom), 1'($urandom)};
                        push_beat(b, 1'b0, '0);
                    end
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Receiver: stretches of always-ready, coin-flip and mostly-stalled,
    // plus one long hold-off when the sender asks for it.
    // ---------------------------------------------------------------------
    initial begin : result_pacing
        int span;
        int mode;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            span = $urandom_range(8, 96);
            mode = $urandom_range(0, 2);
            repeat (span) begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result checker: every result beat against the oldest owed result
    // ---------------------------------------------------------------------
    mv_result_t head;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing owed: status %0d y %h", m_status, m_y_vector);
                fail_count++;
            end else begin
                head = due_results.pop_front();
                if (m_status !== head.status) begin
                    $error("status: expected %0d, got %0d", head.status, m_status);
                    fail_count++;
                end
                if (m_entry_bit !== head.entry_bit) begin
                    $error("entry_bit: expected %0d, got %0d", head.entry_bit, m_entry_bit);
                    fail_count++;
                end
                if (m_y_vector !== head.y_vec) begin
                    $error("y_vector: expected %h, got %h", head.y_vec, m_y_vector);
                    fail_count++;
                end
                if (m_max_row_weight !== head.max_row) begin
                    $error("max_row_weight: expected %0d, got %0d", head.max_row,
                           m_max_row_weight);
                    fail_count++;
                end
                if (m_max_col_weight !== head.max_col) begin
                    $error("max_col_weight: expected %0d, got %0d", head.max_col,
                           m_max_col_weight);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: too long without a beat on either channel ends the run
    // ---------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else                                              idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
